// ===== rtl/clipped_fill_and_keyed_blit_macros.svh =====
// Assertion macros for the checker file of the fill and blit engine.
`ifndef CLIPPED_FILL_AND_KEYED_BLIT_MACROS_SVH
`define CLIPPED_FILL_AND_KEYED_BLIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CFKB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfkb: implication check failed");

// next-cycle implication, quiet during reset
`define CFKB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfkb: next-cycle check failed");

// next-cycle implication that also runs while reset is high
`define CFKB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cfkb: reset check failed");

`endif

// ===== rtl/cfkb_pkg.sv =====
// Shared types and constants of the clipped fill and keyed blit engine.
`default_nettype none

package cfkb_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int SURF_W         = 13;
   localparam int CSR_IDX_W      = 4;

   localparam logic [SURF_W-1:0] SURF_WIDTH_RST  = 13'd320;
   localparam logic [SURF_W-1:0] SURF_HEIGHT_RST = 13'd240;

   localparam logic [CSR_IDX_W-1:0] CSR_SURF_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SURF_HEIGHT = 4'd1;

   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_CMD   = 2'd1;
   localparam logic [1:0] ST_PIXEL = 2'd2;

   typedef enum logic [1:0] {
      REQ_FILL = 2'd0,
      REQ_BLIT = 2'd1,
      REQ_STEP = 2'd2,
      REQ_RSVD = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_FILL = 3'b010,
      MODE_BLIT = 3'b100
   } mode_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] rect_x0;
      logic [31:0] rect_y0;
      logic [31:0] rect_x1;
      logic [31:0] rect_y1;
      logic [15:0] fill_color;
      logic [16:0] color_key;
      logic [15:0] src_pitch;
      logic [15:0] src_pixel;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [24:0] charge_pixels;
      logic        write_enable;
      logic [23:0] dest_offset;
      logic [15:0] write_data;
      logic [31:0] src_offset;
      logic        last;
   } rsp_word_type;

   localparam rsp_word_type RSP_IDLE = '0;

endpackage

`default_nettype wire

// ===== rtl/cfkb_if.sv =====
// Channel interfaces: request words, response words and register writes.
`default_nettype none

interface cfkb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [31:0] rect_x0;
   logic signed [31:0] rect_y0;
   logic signed [31:0] rect_x1;
   logic signed [31:0] rect_y1;
   logic [15:0]        fill_color;
   logic signed [16:0] color_key;
   logic [15:0]        src_pitch;
   logic [15:0]        src_pixel;

   modport source (output valid, req_type, rect_x0, rect_y0, rect_x1, rect_y1,
                   fill_color, color_key, src_pitch, src_pixel, input ready);
   modport sink   (input valid, req_type, rect_x0, rect_y0, rect_x1, rect_y1,
                   fill_color, color_key, src_pitch, src_pixel, output ready);
endinterface

interface cfkb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [24:0] charge_pixels;
   logic        write_enable;
   logic [23:0] dest_offset;
   logic [15:0] write_data;
   logic [31:0] src_offset;
   logic        last;

   modport source (output valid, status, charge_pixels, write_enable, dest_offset,
                   write_data, src_offset, last, input ready);
   modport sink   (input valid, status, charge_pixels, write_enable, dest_offset,
                   write_data, src_offset, last, output ready);
endinterface

interface cfkb_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [12:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/clipped_fill_and_keyed_blit.sv =====
// Top level of the clipped fill and color-keyed blit engine.
// Usage:
//  - csr_ch writes surface_width (index 0) and surface_height (index 1); always ready.
//    Sizes above 2^COORD_BITS act as 2^COORD_BITS. Write only while idle.
//  - req_ch, one word per cycle unless stalled: start fill, start blit, step pixel.
//  - rsp_ch returns exactly one word for each request word, in order.
//  - A start word answers with status 1 and the clipped pixel charge, or status 0
//    when the clip is empty or a blit has zero stride; each step word then
//    answers with one pixel, column by column, last set on the final one.
//  - For a blit, src_offset names the source pixel to send with the next step.
//  - Path: a word accepted into the input register goes through the clip or pixel
//    logic into the response register, from which it is offered on rsp_ch.
//  - Throughput is one word per cycle unless rsp_ch stalls; the pixel walk state
//    advances in the cycle a word moves from input register to response register.
//  - When rsp_ch stalls, the response register holds; req_ch.ready drops in the
//    same cycle once the input register is full, while an empty input register
//    still takes one more word.
//  - Synchronous reset empties both registers, sets 320x240 and goes idle.
`default_nettype none

module clipped_fill_and_keyed_blit import cfkb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   cfkb_req_if.sink   req_ch,
   cfkb_rsp_if.source rsp_ch,
   cfkb_csr_if.sink   csr_ch
);

   localparam int CW = COORD_BITS + 1;
   localparam int EW = (CW > SURF_W) ? CW : SURF_W;
   localparam logic [EW-1:0] SIZE_LIM = EW'(1) << COORD_BITS;

   logic [SURF_W-1:0]     surf_width_ff, surf_height_ff;
   logic [CW-1:0]         sw_eff, sh_eff;

   logic                  in_valid_ff;
   req_word_type          in_word_ff;
   logic                  out_valid_ff;
   rsp_word_type          out_word_ff, out_word_in;
   logic                  advance;

   mode_type              mode_ff, mode_in;
   logic [COORD_BITS-1:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [CW-1:0]         span_cols_ff, span_cols_in, span_rows_ff, span_rows_in;
   logic [CW-1:0]         col_index_ff, col_index_in, row_index_ff, row_index_in;
   logic [15:0]           held_color_ff, held_color_in;
   logic [16:0]           held_key_ff, held_key_in;
   logic [15:0]           held_stride_ff, held_stride_in;
   logic [31:0]           src_column_base_ff, src_column_base_in;

   logic                  clip_ok;
   logic [COORD_BITS-1:0] clip_origin_x, clip_origin_y;
   logic [CW-1:0]         clip_cols, clip_rows;
   logic [24:0]           clip_charge;
   logic [31:0]           clip_src_base;

   rsp_word_type          pixel_word;
   mode_type              walk_mode;
   logic [CW-1:0]         walk_col, walk_row;
   logic [31:0]           walk_base;

   assign sw_eff = CW'((EW'(surf_width_ff) > SIZE_LIM) ? SIZE_LIM : EW'(surf_width_ff));
   assign sh_eff = CW'((EW'(surf_height_ff) > SIZE_LIM) ? SIZE_LIM : EW'(surf_height_ff));

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_width_ff  <= SURF_WIDTH_RST;
         surf_height_ff <= SURF_HEIGHT_RST;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_SURF_WIDTH) begin
            surf_width_ff <= csr_ch.data;
         end
         if (csr_ch.index == CSR_SURF_HEIGHT) begin
            surf_height_ff <= csr_ch.data;
         end
      end
   end

   // two-register pipe: input word register, response word register
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_word_ff.req_type   <= req_ch.req_type;
         in_word_ff.rect_x0    <= req_ch.rect_x0;
         in_word_ff.rect_y0    <= req_ch.rect_y0;
         in_word_ff.rect_x1    <= req_ch.rect_x1;
         in_word_ff.rect_y1    <= req_ch.rect_y1;
         in_word_ff.fill_color <= req_ch.fill_color;
         in_word_ff.color_key  <= req_ch.color_key;
         in_word_ff.src_pitch  <= req_ch.src_pitch;
         in_word_ff.src_pixel  <= req_ch.src_pixel;
      end
   end

   cfkb_clip #(.COORD_BITS(COORD_BITS)) u_clip (
      .surf_w   (sw_eff),
      .surf_h   (sh_eff),
      .rect_x0  (in_word_ff.rect_x0),
      .rect_y0  (in_word_ff.rect_y0),
      .rect_x1  (in_word_ff.rect_x1),
      .rect_y1  (in_word_ff.rect_y1),
      .is_blit  (in_word_ff.req_type == REQ_BLIT),
      .stride   (in_word_ff.src_pitch),
      .clip_ok  (clip_ok),
      .origin_x (clip_origin_x),
      .origin_y (clip_origin_y),
      .cols     (clip_cols),
      .rows     (clip_rows),
      .charge   (clip_charge),
      .src_base (clip_src_base)
   );

   cfkb_walk #(.COORD_BITS(COORD_BITS)) u_walk (
      .mode            (mode_ff),
      .surf_w          (sw_eff),
      .surf_h          (sh_eff),
      .origin_x        (origin_x_ff),
      .origin_y        (origin_y_ff),
      .span_cols       (span_cols_ff),
      .span_rows       (span_rows_ff),
      .col_index       (col_index_ff),
      .row_index       (row_index_ff),
      .held_color      (held_color_ff),
      .held_key        (held_key_ff),
      .held_stride     (held_stride_ff),
      .src_column_base (src_column_base_ff),
      .src_pixel       (in_word_ff.src_pixel),
      .pixel_word      (pixel_word),
      .mode_next       (walk_mode),
      .col_next        (walk_col),
      .row_next        (walk_row),
      .base_next       (walk_base)
   );

   always_comb begin
      mode_in            = mode_ff;
      origin_x_in        = origin_x_ff;
      origin_y_in        = origin_y_ff;
      span_cols_in       = span_cols_ff;
      span_rows_in       = span_rows_ff;
      col_index_in       = col_index_ff;
      row_index_in       = row_index_ff;
      held_color_in      = held_color_ff;
      held_key_in        = held_key_ff;
      held_stride_in     = held_stride_ff;
      src_column_base_in = src_column_base_ff;
      out_word_in        = RSP_IDLE;

      if (advance) begin
         unique case (req_code_type'(in_word_ff.req_type))
            REQ_FILL, REQ_BLIT: begin
               if (clip_ok) begin
                  origin_x_in  = clip_origin_x;
                  origin_y_in  = clip_origin_y;
                  span_cols_in = clip_cols;
                  span_rows_in = clip_rows;
                  col_index_in = '0;
                  row_index_in = '0;
                  out_word_in.status        = ST_CMD;
                  out_word_in.charge_pixels = clip_charge;
                  if (in_word_ff.req_type == REQ_FILL) begin
                     mode_in       = MODE_FILL;
                     held_color_in = in_word_ff.fill_color;
                  end else begin
                     mode_in                = MODE_BLIT;
                     held_key_in            = in_word_ff.color_key;
                     held_stride_in         = in_word_ff.src_pitch;
                     src_column_base_in     = clip_src_base;
                     out_word_in.src_offset = clip_src_base;
                  end
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
            REQ_STEP: begin
               if (mode_ff != MODE_IDLE) begin
                  mode_in            = walk_mode;
                  col_index_in       = walk_col;
                  row_index_in       = walk_row;
                  src_column_base_in = walk_base;
                  out_word_in        = pixel_word;
               end
            end
            REQ_RSVD: begin
               out_word_in = RSP_IDLE;
            end
            default: begin
               out_word_in = RSP_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_IDLE;
         origin_x_ff        <= '0;
         origin_y_ff        <= '0;
         span_cols_ff       <= '0;
         span_rows_ff       <= '0;
         col_index_ff       <= '0;
         row_index_ff       <= '0;
         held_color_ff      <= '0;
         held_key_ff        <= '1;
         held_stride_ff     <= '0;
         src_column_base_ff <= '0;
      end else begin
         mode_ff            <= mode_in;
         origin_x_ff        <= origin_x_in;
         origin_y_ff        <= origin_y_in;
         span_cols_ff       <= span_cols_in;
         span_rows_ff       <= span_rows_in;
         col_index_ff       <= col_index_in;
         row_index_ff       <= row_index_in;
         held_color_ff      <= held_color_in;
         held_key_ff        <= held_key_in;
         held_stride_ff     <= held_stride_in;
         src_column_base_ff <= src_column_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.status        = out_word_ff.status;
   assign rsp_ch.charge_pixels = out_word_ff.charge_pixels;
   assign rsp_ch.write_enable  = out_word_ff.write_enable;
   assign rsp_ch.dest_offset   = out_word_ff.dest_offset;
   assign rsp_ch.write_data    = out_word_ff.write_data;
   assign rsp_ch.src_offset    = out_word_ff.src_offset;
   assign rsp_ch.last          = out_word_ff.last;

endmodule

`default_nettype wire

// ===== rtl/cfkb_clip.sv =====
// Rectangle clipping, pixel charge and first source index for a start word.
`default_nettype none

module cfkb_clip import cfkb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic [COORD_BITS:0]   surf_w,
   input  logic [COORD_BITS:0]   surf_h,
   input  logic [31:0]           rect_x0,
   input  logic [31:0]           rect_y0,
   input  logic [31:0]           rect_x1,
   input  logic [31:0]           rect_y1,
   input  logic                  is_blit,
   input  logic [15:0]           stride,
   output logic                  clip_ok,
   output logic [COORD_BITS-1:0] origin_x,
   output logic [COORD_BITS-1:0] origin_y,
   output logic [COORD_BITS:0]   cols,
   output logic [COORD_BITS:0]   rows,
   output logic [24:0]           charge,
   output logic [31:0]           src_base
);

   localparam int PROD_W = 2 * (COORD_BITS + 1);

   logic [31:0]       x0, y0, x1, y1;
   logic [31:0]       sx0, sy0;
   logic [31:0]       cols_w, rows_w;
   logic [PROD_W-1:0] area;

   always_comb begin
      x0 = rect_x0[31] ? 32'd0 : rect_x0;
      y0 = rect_y0[31] ? 32'd0 : rect_y0;
      x1 = ($signed(rect_x1) > $signed(32'(surf_w))) ? 32'(surf_w) : rect_x1;
      y1 = ($signed(rect_y1) > $signed(32'(surf_h))) ? 32'(surf_h) : rect_y1;

      clip_ok = ($signed(x1) > $signed(x0)) && ($signed(y1) > $signed(y0)) &&
                !(is_blit && (stride == 16'd0));

      cols_w = x1 - x0;
      rows_w = y1 - y0;
      cols   = cols_w[COORD_BITS:0];
      rows   = rows_w[COORD_BITS:0];
      origin_x = x0[COORD_BITS-1:0];
      origin_y = y0[COORD_BITS-1:0];

      area   = PROD_W'(cols) * PROD_W'(rows);
      charge = 25'(area);

      // source skip is the part of the rectangle cut off on the low side
      sx0 = rect_x0[31] ? (32'd0 - rect_x0) : 32'd0;
      sy0 = rect_y0[31] ? (32'd0 - rect_y0) : 32'd0;
      src_base = sy0 * 32'(stride) + sx0;
   end

endmodule

`default_nettype wire

// ===== rtl/cfkb_walk.sv =====
// One pixel step: framebuffer index, data, key test and walk advance.
`default_nettype none

module cfkb_walk import cfkb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  mode_type              mode,
   input  logic [COORD_BITS:0]   surf_w,
   input  logic [COORD_BITS:0]   surf_h,
   input  logic [COORD_BITS-1:0] origin_x,
   input  logic [COORD_BITS-1:0] origin_y,
   input  logic [COORD_BITS:0]   span_cols,
   input  logic [COORD_BITS:0]   span_rows,
   input  logic [COORD_BITS:0]   col_index,
   input  logic [COORD_BITS:0]   row_index,
   input  logic [15:0]           held_color,
   input  logic [16:0]           held_key,
   input  logic [15:0]           held_stride,
   input  logic [31:0]           src_column_base,
   input  logic [15:0]           src_pixel,
   output rsp_word_type          pixel_word,
   output mode_type              mode_next,
   output logic [COORD_BITS:0]   col_next,
   output logic [COORD_BITS:0]   row_next,
   output logic [31:0]           base_next
);

   localparam int CW = COORD_BITS + 1;

   logic [CW-1:0]    x, y;
   logic [23:0]      diff, dest;
   logic [CW:0]      row_inc, col_inc;
   logic             row_wrap, done;
   logic             key_hit;
   logic [CW+15:0]   row_prod;
   logic [31:0]      next_src;

   always_comb begin
      x    = CW'(origin_x) + col_index;
      y    = CW'(origin_y) + row_index;
      // rotated layout: a landscape column runs along one framebuffer row
      diff = 24'(surf_w) - 24'd1 - 24'(x);
      dest = 24'(diff * 24'(surf_h)) + 24'(y);

      row_inc  = (CW+1)'(row_index) + (CW+1)'(1);
      col_inc  = (CW+1)'(col_index) + (CW+1)'(1);
      row_wrap = row_inc >= (CW+1)'(span_rows);
      done     = row_wrap && (col_inc >= (CW+1)'(span_cols));

      row_next  = row_wrap ? '0 : row_inc[CW-1:0];
      col_next  = row_wrap ? (done ? '0 : col_inc[CW-1:0]) : col_index;
      base_next = row_wrap ? (src_column_base + 32'd1) : src_column_base;
      mode_next = done ? MODE_IDLE : mode;

      row_prod = (CW+16)'(row_next) * (CW+16)'(held_stride);
      next_src = (mode_next == MODE_BLIT) ? (base_next + 32'(row_prod)) : 32'd0;

      key_hit = !held_key[16] && (src_pixel == held_key[15:0]);

      pixel_word               = RSP_IDLE;
      pixel_word.status        = ST_PIXEL;
      pixel_word.dest_offset   = dest;
      pixel_word.src_offset    = next_src;
      pixel_word.last          = done;
      if (mode == MODE_BLIT) begin
         pixel_word.write_data   = src_pixel;
         pixel_word.write_enable = !key_hit;
      end else begin
         pixel_word.write_data   = held_color;
         pixel_word.write_enable = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cfkb_checker.sv =====
// Port-level checks for the fill and blit engine, bound to the top level.
`default_nettype none
`include "clipped_fill_and_keyed_blit_macros.svh"

module cfkb_checker import cfkb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [24:0] charge_pixels,
   input logic        write_enable,
   input logic [23:0] dest_offset,
   input logic [15:0] write_data,
   input logic [31:0] src_offset,
   input logic        last
);

   // stalled response word holds
   `CFKB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({status, charge_pixels, write_enable, dest_offset, write_data, src_offset, last}))

   // only pixel words carry pixel fields
   `CFKB_ASSERT_IMPLY(a_nonpixel_clean, clock, reset, rsp_valid && status != ST_PIXEL, !write_enable && dest_offset == 24'd0 && write_data == 16'd0 && !last)

   // an idle answer is all zero
   `CFKB_ASSERT_IMPLY(a_idle_zero, clock, reset, rsp_valid && status == ST_NONE, charge_pixels == 25'd0 && src_offset == 32'd0)

   // an accepted command never charges zero pixels
   `CFKB_ASSERT_IMPLY(a_cmd_charge, clock, reset, rsp_valid && status == ST_CMD, charge_pixels != 25'd0)

   // reset empties the pipe
   `CFKB_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind clipped_fill_and_keyed_blit cfkb_checker u_cfkb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .charge_pixels (rsp_ch.charge_pixels),
   .write_enable  (rsp_ch.write_enable),
   .dest_offset   (rsp_ch.dest_offset),
   .write_data    (rsp_ch.write_data),
   .src_offset    (rsp_ch.src_offset),
   .last          (rsp_ch.last)
);

`default_nettype wire
